// ===== rtl/dncd_pkg.sv =====
package dncd_pkg;

  // Field widths of the two channels.
  localparam int unsigned DayCountW = 21;
  localparam int unsigned DomW      = 5;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned YearW     = 14;
  localparam int unsigned WeekdayW  = 3;

  // Day index after the century correction, one bit wider than the count.
  localparam int unsigned DayIdxW   = 22;

  // Century divider: floor((4*day + bias) / 146097), dividend below 2^23.
  localparam int unsigned DivAInW     = 23;
  localparam int unsigned DivADivisor = 146097;
  localparam int unsigned DivAQW      = 6;

  // Year divider: floor((4*index + bias) / 1461), dividend below 2^24.
  localparam int unsigned DivBInW     = 24;
  localparam int unsigned DivBDivisor = 1461;
  localparam int unsigned DivBQW      = 14;

  typedef logic signed [DayCountW-1:0] day_count_t;
  typedef logic signed [DayIdxW-1:0]   day_index_t;
  typedef logic        [DomW-1:0]      dom_t;
  typedef logic        [MonthW-1:0]    month_t;
  typedef logic signed [YearW-1:0]     year_t;
  typedef logic        [WeekdayW-1:0]  weekday_t;

endpackage

// ===== rtl/day_number_to_calendar_date_unit.sv =====
// Day count to calendar date unit.
// The input channel (in_valid_i, in_ready_o, day_count_i) takes a signed
// count of days since 1899-12-31. The output channel (out_valid_o,
// out_ready_i) returns day of month, month, astronomical year and weekday,
// Sunday being 1. Days after 1582-10-04 follow the Gregorian calendar and
// earlier days the Julian one.
// The pipeline runs from input transfer to result valid through two stages
// for the century divider, one for the index correction, two for the year
// divider and four for the month split and date assembly. One transfer is
// taken every cycle while the receiver keeps up.
// Reset clears every stage valid bit; the pipeline starts empty and there
// is no state beyond it.
// When the receiver stalls, the last stage holds its result and the stages
// behind it keep filling until every stage is full; only then does
// in_ready_o fall. Nothing is dropped or repeated.
module day_number_to_calendar_date_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dncd_pkg::day_count_t  day_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dncd_pkg::dom_t        day_of_month_o,
  output dncd_pkg::month_t      month_number_o,
  output dncd_pkg::year_t       year_number_o,
  output dncd_pkg::weekday_t    weekday_o
);

  import dncd_pkg::*;

  // Century bias 145857 plus fourteen periods of 146097, so that the
  // quotient is the century term with its offset of fourteen included.
  localparam logic signed [DivAInW:0] CentBias = 24'sd2191215;
  localparam int unsigned             SbBW     = WeekdayW + DayIdxW;

  logic signed [DivAInW:0] na_wide;
  logic [DivAInW-1:0]      na;

  logic                    a_valid, a_ready;
  logic [DivAQW-1:0]       a_quot;
  logic [DayCountW-1:0]    a_sb;

  logic                    m_valid, m_ready;
  logic [DivBInW-1:0]      m_dividend;
  day_index_t              m_index;
  weekday_t                m_weekday;

  logic                    b_valid, b_ready;
  logic [DivBQW-1:0]       b_quot;
  logic [SbBW-1:0]         b_sb;

  // Dividend of the century term; only used on the Gregorian side.
  assign na_wide = ($signed((DivAInW+1)'(day_count_i)) <<< 2) + CentBias;
  assign na      = na_wide[DivAInW-1:0];

  dncd_const_div #(
    .InW     (DivAInW),
    .Divisor (DivADivisor),
    .QW      (DivAQW),
    .SbW     (DayCountW)
  ) u_div_century (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .dividend_i (na),
    .sb_i       (day_count_i),
    .valid_o    (a_valid),
    .ready_i    (a_ready),
    .quot_o     (a_quot),
    .sb_o       (a_sb)
  );

  dncd_mid u_mid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (a_valid),
    .ready_o     (a_ready),
    .century_i   (a_quot),
    .day_count_i ($signed(a_sb)),
    .valid_o     (m_valid),
    .ready_i     (m_ready),
    .dividend_o  (m_dividend),
    .day_index_o (m_index),
    .weekday_o   (m_weekday)
  );

  dncd_const_div #(
    .InW     (DivBInW),
    .Divisor (DivBDivisor),
    .QW      (DivBQW),
    .SbW     (SbBW)
  ) u_div_year (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (m_valid),
    .ready_o    (m_ready),
    .dividend_i (m_dividend),
    .sb_i       ({m_weekday, m_index}),
    .valid_o    (b_valid),
    .ready_i    (b_ready),
    .quot_o     (b_quot),
    .sb_o       (b_sb)
  );

  dncd_tail u_tail (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (b_valid),
    .ready_o        (b_ready),
    .cycle_i        (b_quot),
    .day_index_i    ($signed(b_sb[DayIdxW-1:0])),
    .weekday_i      (b_sb[SbBW-1:DayIdxW]),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .day_of_month_o (day_of_month_o),
    .month_number_o (month_number_o),
    .year_number_o  (year_number_o),
    .weekday_o      (weekday_o)
  );

endmodule

// ===== rtl/dncd_const_div.sv =====
module dncd_const_div #(
  parameter int unsigned InW     = dncd_pkg::DivBInW,
  parameter int unsigned Divisor = dncd_pkg::DivBDivisor,
  parameter int unsigned QW      = dncd_pkg::DivBQW,
  parameter int unsigned SbW     = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [InW-1:0] dividend_i,
  input  logic [SbW-1:0] sb_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [QW-1:0]  quot_o,
  output logic [SbW-1:0] sb_o
);

  // Truncated reciprocal: the first estimate is the quotient or one below it.
  localparam logic [QW-1:0]  Recip  = QW'((64'd1 << InW) / Divisor);
  localparam logic [InW-1:0] DivC   = InW'(Divisor);
  localparam logic [InW:0]   Div2C  = (InW+1)'(2 * Divisor);
  localparam int unsigned    PW     = InW + QW;

  logic           v1_q, v2_q;
  logic           rdy1, rdy2;
  logic [PW-1:0]  prod_d, prod_q;
  logic [InW-1:0] num_q;
  logic [SbW-1:0] sb1_q, sb2_q;
  logic [QW-1:0]  q0;
  logic [PW-1:0]  back;
  logic [InW-1:0] rem;
  logic [QW-1:0]  quot_d, quot_q;

  // A stage takes a new transfer when it is empty or its content moves on.
  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // Stage one multiplies by the reciprocal.
  assign prod_d = PW'(dividend_i) * PW'(Recip);

  // Stage two forms the remainder of the estimate and corrects by one.
  assign q0     = prod_q[PW-1:InW];
  assign back   = PW'(q0) * PW'(DivC);
  assign rem    = num_q - back[InW-1:0];
  assign quot_d = (rem >= DivC) ? q0 + QW'(1) : q0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      prod_q <= prod_d;
      num_q  <= dividend_i;
      sb1_q  <= sb_i;
    end
    if (rdy2 && v1_q) begin
      quot_q <= quot_d;
      sb2_q  <= sb1_q;
    end
  end

  assign valid_o = v2_q;
  assign quot_o  = quot_q;
  assign sb_o    = sb2_q;

`ifndef NO_ASSERTIONS
  // The reciprocal estimate never falls more than one below the quotient.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> ({1'b0, rem} < Div2C))
    else $error("divider remainder out of range");

  // An accepted transfer always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && rdy1) |=> v1_q)
    else $error("accepted transfer lost in divider");

  // A blocked first stage keeps its product.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(prod_q)))
    else $error("divider stage changed while blocked");
`endif

endmodule

// ===== rtl/dncd_mid.sv =====
module dncd_mid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [dncd_pkg::DivAQW-1:0]   century_i,
  input  dncd_pkg::day_count_t          day_count_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [dncd_pkg::DivBInW-1:0]  dividend_o,
  output dncd_pkg::day_index_t          day_index_o,
  output dncd_pkg::weekday_t            weekday_o
);

  import dncd_pkg::*;

  localparam int unsigned AdjW = DivAQW + 1;
  localparam int unsigned WkW  = 24;
  localparam day_count_t  GregStart = -21'sd115860;
  // Julian day of the epoch plus one, so that Sunday gives remainder zero.
  localparam logic [WkW-1:0]          WeekBias = 24'd2415021;
  // Offset 1172 of the year term plus 2871 periods of 1461 to stay positive.
  localparam logic signed [DayIdxW+2:0] YearBias = 25'sd4195703;

  logic                      v_q;
  logic                      greg;
  logic [AdjW-1:0]           adj;
  day_index_t                idx_d, idx_q;
  logic signed [DayIdxW+2:0] yw;
  logic [DivBInW-1:0]        dividend_d, dividend_q;
  logic [WkW-1:0]            wk;
  logic [5:0]                dsum;
  logic [3:0]                f1;
  logic [2:0]                f2;
  logic [2:0]                rem7;
  weekday_t                  wd_d, wd_q;

  assign ready_o = !v_q || ready_i;

  // Gregorian correction applies after the calendar switch.
  assign greg  = day_count_i > GregStart;
  assign adj   = AdjW'(century_i) - AdjW'(century_i >> 2) + AdjW'(1);
  assign idx_d = greg ? $signed(DayIdxW'(day_count_i) + DayIdxW'(adj))
                      : DayIdxW'(day_count_i);

  // Dividend of the year term, shifted into the positive range.
  assign yw         = $signed({idx_d[DayIdxW-1], idx_d, 2'b00}) + YearBias;
  assign dividend_d = yw[DivBInW-1:0];

  // Weekday: octal digits summed and folded, since eight is one modulo seven.
  assign wk = WkW'(day_count_i) + WeekBias;

  always_comb begin
    dsum = '0;
    for (int k = 0; k < WkW / 3; k++) begin
      dsum = dsum + 6'(wk[3*k +: 3]);
    end
  end

  assign f1   = 4'(dsum[5:3]) + 4'(dsum[2:0]);
  assign f2   = 3'(f1[3]) + f1[2:0];
  assign rem7 = (f2 == 3'd7) ? 3'd0 : f2;
  assign wd_d = rem7 + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      idx_q      <= idx_d;
      dividend_q <= dividend_d;
      wd_q       <= wd_d;
    end
  end

  assign valid_o     = v_q;
  assign dividend_o  = dividend_q;
  assign day_index_o = idx_q;
  assign weekday_o   = wd_q;

`ifndef NO_ASSERTIONS
  // The folded remainder plus one never wraps to zero.
  a_weekday_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (wd_q != '0))
    else $error("weekday code zero");
`endif

endmodule

// ===== rtl/dncd_tail.sv =====
module dncd_tail (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [dncd_pkg::DivBQW-1:0]  cycle_i,
  input  dncd_pkg::day_index_t         day_index_i,
  input  dncd_pkg::weekday_t           weekday_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output dncd_pkg::dom_t               day_of_month_o,
  output dncd_pkg::month_t             month_number_o,
  output dncd_pkg::year_t              year_number_o,
  output dncd_pkg::weekday_t           weekday_o
);

  import dncd_pkg::*;

  localparam int unsigned BW  = 13;
  localparam int unsigned TW  = 24;
  localparam int unsigned CW  = 9;
  localparam int unsigned NSt = 4;

  localparam logic signed [DivBQW:0] CycleBias = 15'sd2871;
  localparam logic signed [TW-1:0]   YearLen   = 24'sd1461;
  localparam logic signed [TW-1:0]   YearRound = 24'sd3;
  localparam logic signed [TW-1:0]   MonthBase = 24'sd416;
  localparam year_t                  YearEarly = 14'sd1899;
  localparam year_t                  YearLate  = 14'sd1900;
  localparam month_t                 MarchNum  = 4'd3;
  localparam month_t                 WrapMonth = 4'd14;

  // floor(30.6001 * k): days before month term k.
  localparam logic [CW-1:0] MonthDays [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  logic [NSt-1:0]            v_q;
  logic [NSt-1:0]            rdy;

  logic signed [DivBQW:0]    bw;
  logic signed [BW-1:0]      b_d, b1_q, b2_q, b3_q;
  logic signed [TW-1:0]      t_d, t_q;
  day_index_t                idx1_q;
  weekday_t                  wd1_q, wd2_q, wd3_q, wd4_q;
  logic signed [TW-1:0]      cw;
  logic [CW-1:0]             c_d, c2_q, c3_q;
  month_t                    g_d, g3_q;
  logic [CW-1:0]             md;
  logic [CW-1:0]             dom_w;
  dom_t                      dom_d, dom_q;
  month_t                    month_d, month_q;
  year_t                     year_d, year_q;

  // Each stage fills when empty or when its content moves on.
  assign rdy[3]  = !v_q[3] || ready_i;
  assign rdy[2]  = !v_q[2] || rdy[3];
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];

  // Stage one: signed year count and its day total, 1461*b + 3.
  assign bw  = $signed({1'b0, cycle_i}) - CycleBias;
  assign b_d = bw[BW-1:0];
  assign t_d = TW'(b_d) * YearLen + YearRound;

  // Stage two: day within the March-based year.
  assign cw  = TW'(idx1_q) - (t_q >>> 2) + MonthBase;
  assign c_d = cw[CW-1:0];

  // Stage three: month term as the count of month starts already passed.
  always_comb begin
    g_d = '0;
    for (int k = 1; k < 16; k++) begin
      g_d = g_d + MonthW'(c2_q > MonthDays[k]);
    end
  end

  // Stage four: day, month and year.
  assign md      = MonthDays[g3_q];
  assign dom_w   = c3_q - md;
  assign dom_d   = dom_w[DomW-1:0];
  assign month_d = (g3_q >= WrapMonth) ? g3_q - 4'd13 : g3_q - 4'd1;
  assign year_d  = YearW'(b3_q) + ((month_d >= MarchNum) ? YearEarly : YearLate);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NSt; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      t_q    <= t_d;
      b1_q   <= b_d;
      idx1_q <= day_index_i;
      wd1_q  <= weekday_i;
    end
    if (rdy[1] && v_q[0]) begin
      c2_q  <= c_d;
      b2_q  <= b1_q;
      wd2_q <= wd1_q;
    end
    if (rdy[2] && v_q[1]) begin
      g3_q  <= g_d;
      c3_q  <= c2_q;
      b3_q  <= b2_q;
      wd3_q <= wd2_q;
    end
    if (rdy[3] && v_q[2]) begin
      dom_q   <= dom_d;
      month_q <= month_d;
      year_q  <= year_d;
      wd4_q   <= wd3_q;
    end
  end

  assign valid_o        = v_q[3];
  assign day_of_month_o = dom_q;
  assign month_number_o = month_q;
  assign year_number_o  = year_q;
  assign weekday_o      = wd4_q;

`ifndef NO_ASSERTIONS
  // The March-based day stays between the bounds the year term allows.
  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> ((c2_q >= 9'd123) && (c2_q <= 9'd488)))
    else $error("day within year out of range");

  // The month term never falls below March of the prior count.
  a_month_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (g3_q >= 4'd4))
    else $error("month term out of range");
`endif

endmodule
